// ===== src/jexif_pkg.sv =====
// Shared types and constants for the JPEG Exif segment extractor.
// Holds the parse phase enum, status codes, marker values and identifier tags.
// No dependencies.
`default_nettype none

package jexif_pkg;

  typedef enum logic [2:0] {
    PH_SOI_HI  = 3'd0,
    PH_SOI_LO  = 3'd1,
    PH_HEADER  = 3'd2,
    PH_SKIP    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_IDLE    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_NOT_JPEG  = 2'd2,
    ST_NO_EXIF   = 2'd3
  } status_e;

  localparam logic [15:0] MARK_SOI  = 16'hffd8;
  localparam logic [15:0] MARK_APP0 = 16'hffe0;
  localparam logic [15:0] MARK_APP1 = 16'hffe1;

  // Header layout: 2 marker bytes, 2 length bytes, 6 identifier bytes.
  localparam logic [3:0]  HDR_LEN_POS   = 4'd2;
  localparam logic [3:0]  HDR_ID_POS    = 4'd4;
  localparam logic [3:0]  HDR_LAST_POS  = 4'd9;
  localparam logic [15:0] HDR_BODY_LEN  = 16'd8;

  // "Exif\0\0" indexed by identifier byte position.
  function automatic logic [7:0] exif_tag_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h45;
      3'd1:    val = 8'h78;
      3'd2:    val = 8'h69;
      3'd3:    val = 8'h66;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // "JFIF\0" indexed by identifier byte position.
  function automatic logic [7:0] jfif_tag_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h4a;
      3'd1:    val = 8'h46;
      3'd2:    val = 8'h49;
      3'd3:    val = 8'h46;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== src/jexif_in_if.sv =====
// Input channel of the JPEG Exif segment extractor: one file byte per word.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface jexif_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output first_byte, output end_of_file,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input end_of_file,
                  output ready);
endinterface

`default_nettype wire

// ===== src/jexif_out_if.sv =====
// Result channel of the JPEG Exif segment extractor: payload byte and status word.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface jexif_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_payload;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, output payload_byte, output is_payload, output done_res,
                  output status, input ready);
  modport sink   (input valid, input payload_byte, input is_payload, input done_res,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== src/jpeg_exif_segment_extractor.sv =====
// JPEG Exif segment extractor: checks FFD8, walks an optional JFIF APP0 and
// passes out the payload of the Exif APP1 segment, one file byte per word.
// Path: an accepted byte waits in the input register; its result is registered in the result register.
// Throughput: one byte per cycle; the input register drains into the parser
// whenever the result register is empty or being taken.
// Reset: the parser waits for the first start-marker byte; both registers empty.
`default_nettype none

module jpeg_exif_segment_extractor (
  input  wire        clk_i,
  input  wire        rst_ni,
  jexif_in_if.sink   in_i,
  jexif_out_if.source out_o
);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       in_eof_q;

  logic       out_valid_q;
  logic       out_free;
  logic       fire;

  // The parser consumes the held word when the result slot can take a result.
  assign out_free  = !out_valid_q || out_o.ready;
  assign fire      = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q  <= in_i.data_byte;
      in_first_q <= in_i.first_byte;
      in_eof_q   <= in_i.end_of_file;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  jexif_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic [15:0] seg_marker_q, seg_marker_d;
  logic [15:0] seg_length_q, seg_length_d;
  logic [15:0] bytes_rem_q, bytes_rem_d;
  logic        id_match_q, id_match_d;
  logic        jfif_seen_q, jfif_seen_d;

  // Effective state: first_byte restarts the parse on this very word.
  jexif_pkg::phase_e ph;
  logic [3:0]  pos;
  logic [15:0] mark;
  logic [15:0] len;
  logic [15:0] rem;
  logic        idm;
  logic        jseen;

  always_comb begin
    if (in_first_q) begin
      ph    = jexif_pkg::PH_SOI_HI;
      pos   = '0;
      mark  = '0;
      len   = '0;
      rem   = '0;
      idm   = 1'b1;
      jseen = 1'b0;
    end else begin
      ph    = phase_q;
      pos   = hdr_pos_q;
      mark  = seg_marker_q;
      len   = seg_length_q;
      rem   = bytes_rem_q;
      idm   = id_match_q;
      jseen = jfif_seen_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Header datapath: identifier compare and end-of-header decisions
  // ---------------------------------------------------------------------------
  logic [2:0]  id_idx;
  logic        id_match_next;
  logic        hdr_last;
  logic        len_short;
  logic        is_jfif;
  logic        is_exif;
  logic [15:0] body_rem;
  logic [15:0] rem_dec;

  assign id_idx   = 3'(pos - jexif_pkg::HDR_ID_POS);
  assign hdr_last = (pos == jexif_pkg::HDR_LAST_POS);
  assign body_rem = len - jexif_pkg::HDR_BODY_LEN;
  assign rem_dec  = rem - 16'd1;

  always_comb begin
    id_match_next = (pos == 4'd0) ? 1'b1 : idm;
    if (pos >= jexif_pkg::HDR_ID_POS) begin
      if (mark == jexif_pkg::MARK_APP0) begin
        // Last identifier byte is not part of the JFIF tag.
        if (!hdr_last && (in_byte_q != jexif_pkg::jfif_tag_byte(id_idx))) begin
          id_match_next = 1'b0;
        end
      end else if (mark == jexif_pkg::MARK_APP1) begin
        if (in_byte_q != jexif_pkg::exif_tag_byte(id_idx)) begin
          id_match_next = 1'b0;
        end
      end else begin
        id_match_next = 1'b0;
      end
    end
  end

  // Length is complete well before the last header byte.
  assign len_short = (len < jexif_pkg::HDR_BODY_LEN);
  assign is_jfif   = !jseen && (mark == jexif_pkg::MARK_APP0) && id_match_next;
  assign is_exif   = (mark == jexif_pkg::MARK_APP1) && id_match_next;

  // ---------------------------------------------------------------------------
  // Result decode
  // ---------------------------------------------------------------------------
  logic                res_emit;
  logic                res_done;
  logic                res_live;
  jexif_pkg::status_e  res_status;
  logic [7:0]          res_byte;
  logic                res_is_payload;

  always_comb begin
    res_emit       = 1'b0;
    res_done       = 1'b0;
    res_live       = 1'b1;
    res_status     = jexif_pkg::ST_OK;
    res_byte       = '0;
    res_is_payload = 1'b0;
    unique case (ph)
      jexif_pkg::PH_SOI_HI: begin
        if (in_byte_q != jexif_pkg::MARK_SOI[15:8]) begin
          res_done   = 1'b1;
          res_status = jexif_pkg::ST_NOT_JPEG;
        end
      end
      jexif_pkg::PH_SOI_LO: begin
        if (in_byte_q != jexif_pkg::MARK_SOI[7:0]) begin
          res_done   = 1'b1;
          res_status = jexif_pkg::ST_NOT_JPEG;
        end
      end
      jexif_pkg::PH_HEADER: begin
        if (hdr_last) begin
          if (len_short) begin
            res_done   = 1'b1;
            res_status = jexif_pkg::ST_NO_EXIF;
          end else if (is_jfif) begin
            res_done = 1'b0;
          end else if (is_exif) begin
            // Empty Exif body ends the file right here.
            res_done = (body_rem == 16'd0);
          end else begin
            res_done   = 1'b1;
            res_status = jexif_pkg::ST_NO_EXIF;
          end
        end
      end
      jexif_pkg::PH_SKIP: begin
        res_done = 1'b0;
      end
      jexif_pkg::PH_PAYLOAD: begin
        res_emit       = 1'b1;
        res_byte       = in_byte_q;
        res_is_payload = 1'b1;
        res_done       = (rem_dec == 16'd0);
      end
      default: begin
        // Idle after done: drop the word.
        res_live = 1'b0;
      end
    endcase

    if (res_live) begin
      if (res_done) begin
        res_emit = 1'b1;
      end else if (in_eof_q) begin
        res_emit   = 1'b1;
        res_done   = 1'b1;
        res_status = jexif_pkg::ST_TRUNCATED;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d      = ph;
    hdr_pos_d    = pos;
    seg_marker_d = mark;
    seg_length_d = len;
    bytes_rem_d  = rem;
    id_match_d   = idm;
    jfif_seen_d  = jseen;
    unique case (ph)
      jexif_pkg::PH_SOI_HI: begin
        phase_d = jexif_pkg::PH_SOI_LO;
      end
      jexif_pkg::PH_SOI_LO: begin
        phase_d   = jexif_pkg::PH_HEADER;
        hdr_pos_d = '0;
      end
      jexif_pkg::PH_HEADER: begin
        id_match_d = id_match_next;
        if (pos < jexif_pkg::HDR_LEN_POS) begin
          seg_marker_d = {mark[7:0], in_byte_q};
        end else if (pos < jexif_pkg::HDR_ID_POS) begin
          seg_length_d = {len[7:0], in_byte_q};
        end
        if (!hdr_last) begin
          hdr_pos_d = pos + 4'd1;
        end else begin
          hdr_pos_d = '0;
          if (!len_short && is_jfif) begin
            jfif_seen_d = 1'b1;
            bytes_rem_d = body_rem;
            phase_d     = (body_rem != 16'd0) ? jexif_pkg::PH_SKIP : jexif_pkg::PH_HEADER;
          end else if (!len_short && is_exif) begin
            bytes_rem_d = body_rem;
            phase_d     = jexif_pkg::PH_PAYLOAD;
          end
        end
      end
      jexif_pkg::PH_SKIP: begin
        bytes_rem_d = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_d   = jexif_pkg::PH_HEADER;
          hdr_pos_d = '0;
        end
      end
      jexif_pkg::PH_PAYLOAD: begin
        bytes_rem_d = rem_dec;
      end
      default: begin
        phase_d = jexif_pkg::PH_IDLE;
      end
    endcase
    // Any final result parks the parser until the next file.
    if (res_done) begin
      phase_d = jexif_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= jexif_pkg::PH_SOI_HI;
      hdr_pos_q    <= '0;
      seg_marker_q <= '0;
      seg_length_q <= '0;
      bytes_rem_q  <= '0;
      id_match_q   <= 1'b1;
      jfif_seen_q  <= 1'b0;
    end else if (fire) begin
      phase_q      <= phase_d;
      hdr_pos_q    <= hdr_pos_d;
      seg_marker_q <= seg_marker_d;
      seg_length_q <= seg_length_d;
      bytes_rem_q  <= bytes_rem_d;
      id_match_q   <= id_match_d;
      jfif_seen_q  <= jfif_seen_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [7:0] out_byte_q;
  logic       out_is_payload_q;
  logic       out_done_q;
  logic [1:0] out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && res_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_emit) begin
      out_byte_q       <= res_byte;
      out_is_payload_q <= res_is_payload;
      out_done_q       <= res_done;
      out_status_q     <= res_status;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.payload_byte = out_byte_q;
  assign out_o.is_payload   = out_is_payload_q;
  assign out_o.done_res     = out_done_q;
  assign out_o.status       = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A result without a payload byte is always the final one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_is_payload_q |-> out_done_q)
    else $error("non-payload result not marked done");

  // A nonzero status only travels on the final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != 2'(jexif_pkg::ST_OK)) |-> out_done_q)
    else $error("status set on a result that is not done");

  // Header byte index never runs past the last header byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_pos_q <= jexif_pkg::HDR_LAST_POS)
    else $error("header position out of range");

  // A final result parks the parser.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_emit && res_done |=> phase_q == jexif_pkg::PH_IDLE)
    else $error("parser not idle after final result");

  // A consumed word leaves the result slot loaded exactly when it emits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q == $past(res_emit))
    else $error("result register out of step with parser");

endmodule

`default_nettype wire

// ===== test/jpeg_exif_segment_extractor_test.sv =====
// Self-checking testbench for the JPEG Exif segment extractor: file byte streams in,
// payload and status words out, checked against a scoreboard that tracks the parse.
// Depends on jexif_pkg, jexif_in_if, jexif_out_if and jpeg_exif_segment_extractor.

module jpeg_exif_segment_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Identifier strings as packed bytes, first byte in the top lane.
  localparam logic [47:0] EXIF_TAG    = 48'h45_78_69_66_00_00;
  localparam logic [39:0] JFIF_TAG    = 40'h4a_46_49_46_00;
  localparam int          LIVE_BYTES  = 1400;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_LIMIT = 2000;

  typedef struct packed {
    logic [7:0]         payload_byte;
    logic               is_payload;
    logic               done_res;
    jexif_pkg::status_e status;
  } exif_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_file;
  } file_byte_t;

  // Scoreboard: tracks the parse of the byte stream and keeps the words it must produce.
  class exif_scoreboard;
    jexif_pkg::phase_e ph;
    logic [3:0]  hdr_pos;
    logic [15:0] marker;
    logic [15:0] seg_len;
    logic [15:0] remaining;
    bit          id_ok;
    bit          jfif_seen;
    exif_word_t  expected_q[$];
    int          n_err;
    int          n_bytes;
    int          n_words;
    int          n_payload;
    int          n_status[4];

    function new();
      restart();
    endfunction

    function void restart();
      ph        = jexif_pkg::PH_SOI_HI;
      hdr_pos   = 4'd0;
      marker    = 16'd0;
      seg_len   = 16'd0;
      remaining = 16'd0;
      id_ok     = 1'b1;
      jfif_seen = 1'b0;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      n_err++;
    endtask

    // Note one accepted file byte and queue the word it causes, if any.
    function void note_byte(input logic [7:0] b, input logic first, input logic eof);
      exif_word_t w;
      bit         emit;
      int         pos;
      w    = '{payload_byte: 8'd0, is_payload: 1'b0, done_res: 1'b0,
               status: jexif_pkg::ST_OK};
      emit = 1'b0;
      n_bytes++;
      if (first) restart();
      if (ph == jexif_pkg::PH_IDLE) return;
      case (ph)
        jexif_pkg::PH_SOI_HI: begin
          if (b != jexif_pkg::MARK_SOI[15:8]) begin
            w.done_res = 1'b1; w.status = jexif_pkg::ST_NOT_JPEG; emit = 1'b1;
          end else begin
            ph = jexif_pkg::PH_SOI_LO;
          end
        end
        jexif_pkg::PH_SOI_LO: begin
          if (b != jexif_pkg::MARK_SOI[7:0]) begin
            w.done_res = 1'b1; w.status = jexif_pkg::ST_NOT_JPEG; emit = 1'b1;
          end else begin
            ph = jexif_pkg::PH_HEADER; hdr_pos = 4'd0;
          end
        end
        jexif_pkg::PH_HEADER: begin
          pos = hdr_pos;
          if (pos == 0) id_ok = 1'b1;
          if (pos < 2) begin
            marker = {marker[7:0], b};
          end else if (pos < 4) begin
            seg_len = {seg_len[7:0], b};
          end else if (marker == jexif_pkg::MARK_APP0) begin
            // the sixth identifier byte of a JFIF header is a don't-care
            if (pos < 9 && b != JFIF_TAG[39 - 8 * (pos - 4) -: 8]) id_ok = 1'b0;
          end else if (marker == jexif_pkg::MARK_APP1) begin
            if (b != EXIF_TAG[47 - 8 * (pos - 4) -: 8]) id_ok = 1'b0;
          end else begin
            id_ok = 1'b0;
          end
          if (pos < 9) begin
            hdr_pos = 4'(pos + 1);
          end else begin
            // judge the header on its tenth byte; a short length wins over the identifier
            hdr_pos = 4'd0;
            if (seg_len < 16'd8) begin
              w.done_res = 1'b1; w.status = jexif_pkg::ST_NO_EXIF; emit = 1'b1;
            end else if (!jfif_seen && marker == jexif_pkg::MARK_APP0 && id_ok) begin
              jfif_seen = 1'b1;
              remaining = seg_len - 16'd8;
              ph = (remaining != 16'd0) ? jexif_pkg::PH_SKIP : jexif_pkg::PH_HEADER;
            end else if (marker == jexif_pkg::MARK_APP1 && id_ok) begin
              remaining = seg_len - 16'd8;
              if (remaining == 16'd0) begin
                w.done_res = 1'b1; w.status = jexif_pkg::ST_OK; emit = 1'b1;
              end else begin
                ph = jexif_pkg::PH_PAYLOAD;
              end
            end else begin
              w.done_res = 1'b1; w.status = jexif_pkg::ST_NO_EXIF; emit = 1'b1;
            end
          end
        end
        jexif_pkg::PH_SKIP: begin
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) begin
            ph = jexif_pkg::PH_HEADER; hdr_pos = 4'd0;
          end
        end
        jexif_pkg::PH_PAYLOAD: begin
          w.payload_byte = b; w.is_payload = 1'b1; emit = 1'b1;
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) begin
            w.done_res = 1'b1; w.status = jexif_pkg::ST_OK;
          end
        end
        default: begin
          ph = jexif_pkg::PH_IDLE;
          return;
        end
      endcase
      if (w.done_res) begin
        ph = jexif_pkg::PH_IDLE;
      end else if (eof) begin
        w.done_res = 1'b1; w.status = jexif_pkg::ST_TRUNCATED; emit = 1'b1;
        ph = jexif_pkg::PH_IDLE;
      end
      if (emit) expected_q.push_back(w);
    endfunction

    // Compare one taken result word with the oldest one queued.
    task check_word(input exif_word_t got);
      exif_word_t want;
      n_words++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word: byte %02h payload %0b done %0b status %0d",
                                  got.payload_byte, got.is_payload, got.done_res, got.status));
        return;
      end
      want = expected_q.pop_front();
      if (want.is_payload) n_payload++;
      if (want.done_res) n_status[want.status]++;
      if (got.payload_byte !== want.payload_byte)
        report_mismatch($sformatf("payload_byte %02h, want %02h",
                                  got.payload_byte, want.payload_byte));
      if (got.is_payload !== want.is_payload)
        report_mismatch($sformatf("is_payload %0b, want %0b", got.is_payload, want.is_payload));
      if (got.done_res !== want.done_res)
        report_mismatch($sformatf("done_res %0b, want %0b", got.done_res, want.done_res));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  jexif_in_if  in_ch();
  jexif_out_if out_ch();

  jpeg_exif_segment_extractor DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  exif_scoreboard sb = new();

  logic [7:0] file_q[$];   // file under construction
  file_byte_t stim_q[$];   // every byte word to send, in order
  int         n_live;      // bytes that the parser acts on (up to each end of file)
  int         n_files;
  int         n_holds;
  bit         hold_req;

  // Append one 10-byte segment header to the file under construction.
  task automatic add_header(input logic [15:0] mark, input logic [15:0] len,
                            input logic [47:0] id);
    file_q.push_back(mark[15:8]);
    file_q.push_back(mark[7:0]);
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    for (int k = 0; k < 6; k++) file_q.push_back(id[47 - 8 * k -: 8]);
  endtask

  // Move the file under construction into the stimulus, flagging its first and last bytes.
  task automatic append_file(input bit lead_first, input int eof_at);
    file_byte_t fb;
    foreach (file_q[k]) begin
      fb.data_byte   = file_q[k];
      fb.first_byte  = (k == 0) ? lead_first : 1'b0;
      fb.end_of_file = (k == eof_at);
      stim_q.push_back(fb);
      if (eof_at < 0 || k <= eof_at) n_live++;
    end
    n_files++;
  endtask

  // Draw a random wait; now and then run a stretch with no waits at all.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 60);
    return $urandom_range(0, 8);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("jpeg_exif_segment_extractor test failed");
    $finish;
  end

  // Check a result word before noting the byte of the same edge: a byte accepted now
  // cannot cause the word leaving now.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_word('{payload_byte: out_ch.payload_byte, is_payload: out_ch.is_payload,
                        done_res: out_ch.done_res,
                        status: jexif_pkg::status_e'(out_ch.status)});
      if (in_ch.valid && in_ch.ready)
        sb.note_byte(in_ch.data_byte, in_ch.first_byte, in_ch.end_of_file);
    end
  end

  // Result side: take words after random stalls; on request, hold ready low for a long
  // stretch so the block fills up and pushes back on its input.
  initial begin
    int stall;
    int calm;
    calm = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n_holds++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = draw_wait(calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // Byte side: build the stimulus, reset once, feed every byte, drain and judge.
  initial begin
    int          gap;
    int          calm;
    int          kind;
    int          n;
    int          skip;
    int          plen;
    int          second;
    int          fate;
    int          idx;
    int          eof_at;
    int          waited;
    logic [15:0] len;

    calm     = 0;
    n_live   = 0;
    n_files  = 0;
    n_holds  = 0;
    hold_req = 1'b0;
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= 8'd0;
    in_ch.first_byte  <= 1'b0;
    in_ch.end_of_file <= 1'b0;

    // Directed part.
    // Right after reset the first byte starts a file even without first_byte; a bad
    // start marker ends it, and the byte after that is ignored.
    file_q = '{8'h00, 8'h55};
    append_file(1'b0, -1);
    // Good first marker byte, bad second one.
    file_q = '{8'hff, 8'h00};
    append_file(1'b1, -1);
    // File cut short after one byte.
    file_q = '{8'hff};
    append_file(1'b1, 0);
    // File abandoned mid-header by the start of the next one.
    file_q = '{8'hff, 8'hd8, 8'hff};
    append_file(1'b1, -1);
    // Exif segment with a single all-ones payload byte.
    file_q = '{8'hff, 8'hd8};
    add_header(jexif_pkg::MARK_APP1, 16'd9, EXIF_TAG);
    file_q.push_back(8'hff);
    append_file(1'b1, file_q.size() - 1);

    // Random part: mostly well-formed files with random content, some damaged, some noise.
    while (n_live < LIVE_BYTES) begin
      file_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        // noise, half of it behind a valid start marker
        if (kind < 3) begin
          file_q.push_back(jexif_pkg::MARK_SOI[15:8]);
          file_q.push_back(jexif_pkg::MARK_SOI[7:0]);
        end
        n = $urandom_range(1, 14);
        repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
        eof_at = file_q.size() - 1;
      end else begin
        file_q.push_back(jexif_pkg::MARK_SOI[15:8]);
        file_q.push_back(jexif_pkg::MARK_SOI[7:0]);
        // optional JFIF segment ahead of the Exif one, sometimes with nothing to skip
        if ($urandom_range(0, 2) != 0) begin
          skip = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          add_header(jexif_pkg::MARK_APP0, 16'(8 + skip),
                     {JFIF_TAG, 8'($urandom_range(0, 255))});
          repeat (skip) file_q.push_back(8'($urandom_range(0, 255)));
        end
        plen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 20);
        if ($urandom_range(0, 19) == 0) plen = $urandom_range(21, 60);
        second = $urandom_range(0, 99);
        if (second < 5) begin
          // a JFIF header where the Exif one belongs
          add_header(jexif_pkg::MARK_APP0, 16'(8 + plen),
                     {JFIF_TAG, 8'($urandom_range(0, 255))});
        end else if (second < 10) begin
          // length too short to hold the header body
          add_header(jexif_pkg::MARK_APP1, 16'($urandom_range(0, 7)), EXIF_TAG);
        end else if (second < 14) begin
          add_header({8'hff, 8'($urandom_range(0, 255))}, 16'(8 + plen), EXIF_TAG);
        end else if (second < 18) begin
          // huge length; the file always ends long before the payload does
          len = 16'($urandom_range(16'h8000, 16'hffff));
          add_header(jexif_pkg::MARK_APP1, len, EXIF_TAG);
          plen = $urandom_range(1, 30);
        end else begin
          add_header(jexif_pkg::MARK_APP1, 16'(8 + plen), EXIF_TAG);
        end
        repeat (plen) file_q.push_back(8'($urandom_range(0, 255)));
        // flip one bit somewhere: marker, length, identifier or payload
        if ($urandom_range(0, 9) == 0) begin
          idx = $urandom_range(0, file_q.size() - 1);
          file_q[idx] = file_q[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        fate = $urandom_range(0, 19);
        if (fate == 0) eof_at = -1;
        else if (fate < 3) eof_at = $urandom_range(0, file_q.size() - 1);
        else eof_at = file_q.size() - 1;
        if (eof_at >= 0) begin
          while (file_q.size() > eof_at + 1) void'(file_q.pop_back());
        end
      end
      // one to three stray bytes after the file; the block must drop them once the file has ended
      if ($urandom_range(0, 19) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
      end
      append_file(1'b1, eof_at);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_q[i]) begin
      if (i == stim_q.size() / 3 || i == 2 * stim_q.size() / 3) hold_req = 1'b1;
      gap = draw_wait(calm);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_ch.valid       <= 1'b1;
      in_ch.data_byte   <= stim_q[i].data_byte;
      in_ch.first_byte  <= stim_q[i].first_byte;
      in_ch.end_of_file <= stim_q[i].end_of_file;
      // hold the word until the block takes it
      @(posedge clk_i);
      while (!in_ch.ready) @(posedge clk_i);
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every queued word, then keep watching to catch strays.
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d expected words never arrived", sb.expected_q.size()));

    $display("Run: %0d files, %0d bytes sent, %0d result words (%0d payload), %0d long stalls",
             n_files, sb.n_bytes, sb.n_words, sb.n_payload, n_holds);
    $display("Files ended ok %0d, truncated %0d, not JPEG %0d, no Exif %0d; mismatches %0d",
             sb.n_status[jexif_pkg::ST_OK], sb.n_status[jexif_pkg::ST_TRUNCATED],
             sb.n_status[jexif_pkg::ST_NOT_JPEG], sb.n_status[jexif_pkg::ST_NO_EXIF],
             sb.n_err);
    if (sb.n_err == 0) begin
      $display("jpeg_exif_segment_extractor test passed");
    end else begin
      $display("jpeg_exif_segment_extractor test failed");
    end
    $finish;
  end

endmodule
